### sv/cbk_pkg.sv
`timescale 1ns / 1ps
package cbk_pkg;

  localparam int unsigned CoordW  = 32;
  localparam int unsigned ScaleW  = 24;
  localparam int unsigned ValW    = 32;
  localparam int unsigned SumW    = 34;
  localparam int unsigned RadW    = 17;
  localparam int unsigned SqW     = 33;
  localparam int unsigned CuW     = 49;
  localparam int unsigned DivW    = 35;
  localparam int unsigned ScaleReset = 65536;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_AXIS,
    ST_MERGE,
    ST_OUT
  } cbk_state_e;

  typedef enum logic [2:0] {
    LN_IDLE,
    LN_SCALE,
    LN_PREP,
    LN_SQ,
    LN_CU,
    LN_SPL,
    LN_ACC
  } cbk_lane_e;

  typedef struct packed {
    logic            done;
    logic [ValW-1:0] sum;
  } lane_out_t;

  // floor(p * scale / 2^16), saturated to signed 32 bits
  function automatic logic signed [CoordW-1:0] scale_coord(
    input logic signed [CoordW-1:0] p,
    input logic        [ScaleW-1:0] s
  );
    logic signed [CoordW+ScaleW:0] prod;
    logic signed [CoordW+ScaleW-16:0] sh;
    logic signed [CoordW-1:0] res;
    prod = p * $signed({1'b0, s});
    sh = (CoordW + ScaleW - 15)'(prod >>> 16);
    if (sh > $signed((CoordW + ScaleW - 15)'(33'sh0_7fff_ffff))) begin
      res = 32'sh7fff_ffff;
    end else if (sh < -$signed((CoordW + ScaleW - 15)'(34'sh0_8000_0000))) begin
      res = 32'sh8000_0000;
    end else begin
      res = sh[CoordW-1:0];
    end
    return res;
  endfunction

  // floor(x / 3) using 2^18 = 1 mod 3 and 2^10 = 1 mod 3
  function automatic logic [SumW-1:0] div3(input logic [DivW-1:0] x);
    logic [16:0] h;
    logic [18:0] y;
    logic [10:0] z;
    logic [21:0] zq;
    logic [SumW-1:0] q;
    h  = x[34:18];
    y  = {2'b0, h} + {1'b0, x[17:0]};
    z  = {2'b0, y[18:10]} + {1'b0, y[9:0]};
    zq = 22'(z) * 22'd683;
    q  = SumW'(h) * SumW'(87381) + SumW'(y[18:10]) * SumW'(341) + SumW'(zq[21:11]);
    return q;
  endfunction

endpackage

### sv/cbk_lane.sv
`timescale 1ns / 1ps
module cbk_lane (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic signed [cbk_pkg::CoordW-1:0]   a_i,
  input  logic signed [cbk_pkg::CoordW-1:0]   b_i,
  input  logic        [cbk_pkg::ScaleW-1:0]   scale_i,
  output cbk_pkg::lane_out_t                  out_o
);

  cbk_pkg::cbk_lane_e state_q, state_d;
  logic [1:0] idx_q;
  logic       done_q;

  logic signed [cbk_pkg::CoordW-1:0] p_q [2];
  logic [cbk_pkg::RadW-1:0] m_q [2];
  logic                     inner_q [2];
  logic                     zero_q [2];
  logic [cbk_pkg::SqW-1:0]  sq_q [2];
  logic [cbk_pkg::CuW-1:0]  cu_q [2];
  logic [cbk_pkg::ValW-1:0] spl_q [2];
  logic [cbk_pkg::SumW-1:0] sum_q;

  // offsets of the four lattice points around the first point
  logic signed [18:0] off;
  logic signed [18:0] ta;
  logic signed [33:0] rv [2];
  logic [33:0]        absv [2];
  logic [cbk_pkg::RadW-1:0] m_d [2];
  logic               inner_d [2];
  logic               zero_d [2];
  logic [cbk_pkg::ValW-1:0] spl_d [2];
  logic [cbk_pkg::DivW-1:0] xin [2];
  logic [63:0]        term;

  always_comb begin
    unique case (idx_q)
      2'd0:    off = 19'sd65536;
      2'd1:    off = 19'sd0;
      2'd2:    off = -19'sd65536;
      default: off = -19'sd131072;
    endcase
    ta = $signed({3'b0, p_q[0][15:0]}) + off;
    rv[0] = 34'(ta);
    rv[1] = 34'(p_q[1]) - 34'(p_q[0]) + 34'(ta);
    for (int k = 0; k < 2; k++) begin
      absv[k]    = rv[k][33] ? 34'(-rv[k]) : 34'(rv[k]);
      zero_d[k]  = absv[k] >= 34'd131072;
      inner_d[k] = absv[k] < 34'd65536;
      m_d[k]     = inner_d[k] ? absv[k][16:0] : 17'(18'd131072 - absv[k][17:0]);
    end
  end

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      if (inner_q[k]) begin
        xin[k] = 35'h2_0000_0000 + 35'((51'(cu_q[k]) * 51'd3) >> 17);
      end else begin
        xin[k] = 35'(cu_q[k] >> 17);
      end
      if (zero_q[k]) begin
        spl_d[k] = '0;
      end else if (inner_q[k]) begin
        spl_d[k] = 32'(cbk_pkg::div3(xin[k]) - 34'(sq_q[k]));
      end else begin
        spl_d[k] = 32'(cbk_pkg::div3(xin[k]));
      end
    end
    term = 64'(spl_q[0]) * 64'(spl_q[1]);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      cbk_pkg::LN_IDLE:  if (start_i) state_d = cbk_pkg::LN_SCALE;
      cbk_pkg::LN_SCALE: state_d = cbk_pkg::LN_PREP;
      cbk_pkg::LN_PREP:  state_d = cbk_pkg::LN_SQ;
      cbk_pkg::LN_SQ:    state_d = cbk_pkg::LN_CU;
      cbk_pkg::LN_CU:    state_d = cbk_pkg::LN_SPL;
      cbk_pkg::LN_SPL:   state_d = cbk_pkg::LN_ACC;
      cbk_pkg::LN_ACC:   state_d = (idx_q == 2'd3) ? cbk_pkg::LN_IDLE : cbk_pkg::LN_PREP;
      default:           state_d = cbk_pkg::LN_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cbk_pkg::LN_IDLE;
      idx_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= (state_q == cbk_pkg::LN_ACC) && (idx_q == 2'd3);
      if (state_q == cbk_pkg::LN_IDLE) begin
        idx_q <= '0;
      end else if (state_q == cbk_pkg::LN_ACC) begin
        idx_q <= idx_q + 2'd1;
      end
    end
  end

  // the axis sum is held in idle until the next item starts
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      cbk_pkg::LN_IDLE: begin
        p_q[0] <= a_i;
        p_q[1] <= b_i;
      end
      cbk_pkg::LN_SCALE: begin
        sum_q <= '0;
        for (int k = 0; k < 2; k++) p_q[k] <= cbk_pkg::scale_coord(p_q[k], scale_i);
      end
      cbk_pkg::LN_PREP: begin
        for (int k = 0; k < 2; k++) begin
          m_q[k]     <= m_d[k];
          inner_q[k] <= inner_d[k];
          zero_q[k]  <= zero_d[k];
        end
      end
      cbk_pkg::LN_SQ: begin
        for (int k = 0; k < 2; k++) sq_q[k] <= 33'(34'(m_q[k]) * 34'(m_q[k]));
      end
      cbk_pkg::LN_CU: begin
        for (int k = 0; k < 2; k++) cu_q[k] <= 49'(50'(sq_q[k]) * 50'(m_q[k]));
      end
      cbk_pkg::LN_SPL: begin
        for (int k = 0; k < 2; k++) spl_q[k] <= spl_d[k];
      end
      cbk_pkg::LN_ACC: begin
        sum_q <= sum_q + 34'(term[63:32]);
      end
      default: ;
    endcase
  end

  assign out_o.done = done_q;
  assign out_o.sum  = (sum_q[33:32] != 2'b00) ? '1 : sum_q[31:0];

endmodule

### sv/cubic_bspline_kernel_3d_unit.sv
`timescale 1ns / 1ps
// one item at a time: a new input is taken only in idle, once the last result is registered
// the pace of each item is set by the lane sequencer
//   (five steps for each of the four lattice points on an axis)
// a finished result waits in the output register while the next item runs
// reset: asynchronous active low, scale_factor returns to 1.0 (65536)
module cubic_bspline_kernel_3d_unit #(
  parameter int unsigned DIMENSIONS = 3
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // point_a_x, point_a_y, point_a_z, point_b_x, point_b_y, point_b_z
  input  logic [191:0]  s_axis_tdata,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // kernel_value
  output logic [31:0]   m_axis_tdata,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [23:0]   cfg_data_i
);

  localparam int unsigned CntW = (DIMENSIONS > 1) ? $clog2(DIMENSIONS) : 1;

  cbk_pkg::cbk_state_e state_q, state_d;
  logic [cbk_pkg::ScaleW-1:0] scale_q;
  logic [CntW-1:0]            cnt_q;
  logic [cbk_pkg::ValW-1:0]   acc_q;
  logic                       out_valid_q;
  logic [cbk_pkg::ValW-1:0]   out_data_q;

  cbk_pkg::lane_out_t         lane_out [DIMENSIONS];
  logic [cbk_pkg::ValW-1:0]   sums [2**CntW];
  logic [DIMENSIONS-1:0]      done_vec;
  logic                       in_fire;
  logic                       out_free;
  logic [63:0]                prod;

  assign in_fire     = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || m_axis_tready;

  for (genvar d = 0; d < DIMENSIONS; d++) begin : g_lane
    cbk_lane u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .start_i (in_fire),
      .a_i     ($signed(s_axis_tdata[32*d +: 32])),
      .b_i     ($signed(s_axis_tdata[32*(d+3) +: 32])),
      .scale_i (scale_q),
      .out_o   (lane_out[d])
    );
    assign done_vec[d] = lane_out[d].done;
  end

  always_comb begin
    for (int i = 0; i < 2**CntW; i++) begin
      sums[i] = (i < DIMENSIONS) ? lane_out[i].sum : '0;
    end
  end

  assign prod = 64'(acc_q) * 64'(sums[cnt_q]);

  always_comb begin
    state_d       = state_q;
    s_axis_tready = 1'b0;
    unique case (state_q)
      cbk_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) state_d = cbk_pkg::ST_AXIS;
      end
      cbk_pkg::ST_AXIS: begin
        if (&done_vec) state_d = (DIMENSIONS > 1) ? cbk_pkg::ST_MERGE : cbk_pkg::ST_OUT;
      end
      cbk_pkg::ST_MERGE: begin
        if (cnt_q == CntW'(DIMENSIONS - 1)) state_d = cbk_pkg::ST_OUT;
      end
      cbk_pkg::ST_OUT: begin
        if (out_free) state_d = cbk_pkg::ST_IDLE;
      end
      default: state_d = cbk_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cbk_pkg::ST_IDLE;
      scale_q     <= cbk_pkg::ScaleW'(cbk_pkg::ScaleReset);
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) scale_q <= cfg_data_i;
      if (state_q == cbk_pkg::ST_AXIS) begin
        cnt_q <= CntW'(1);
      end else if (state_q == cbk_pkg::ST_MERGE) begin
        cnt_q <= cnt_q + CntW'(1);
      end
      if (state_q == cbk_pkg::ST_OUT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == cbk_pkg::ST_AXIS) begin
      acc_q <= sums[0];
    end else if (state_q == cbk_pkg::ST_MERGE) begin
      acc_q <= prod[63:32];
    end
    if (state_q == cbk_pkg::ST_OUT && out_free) out_data_q <= acc_q;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

### sv/cbk_checker.sv
`timescale 1ns / 1ps
module cbk_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [31:0]  m_axis_tdata,
  input logic         cfg_ready_o
);

  // a stalled result keeps its data
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // one item in flight: busy right after a transaction
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while busy");

  // no result can appear right after an input with the output empty
  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && !m_axis_tvalid |=> !m_axis_tvalid)
    else $error("result too early");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_o)
    else $error("config port not ready");

endmodule

bind cubic_bspline_kernel_3d_unit cbk_checker u_cbk_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .cfg_ready_o   (cfg_ready_o)
);
